// ===== hw/rtl/tcns_pkg.sv =====
// Shared types, codes and the note period table of the note sequencer.
// No dependencies; used by every file of the block but tcns_stream_if.
`default_nettype none

package tcns_pkg;

  localparam int unsigned MAX_CH = 3;
  localparam int unsigned CH_W   = 2;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_STOP  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_BYTE  = 2'd3;

  localparam logic [1:0] KIND_FETCH   = 2'd0;
  localparam logic [1:0] KIND_FRAME   = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [7:0] META_NOTE_BIT = 8'h80;
  localparam logic [2:0] DUR_RESTART   = 3'd0;
  localparam logic [2:0] DUR_EXTENDED  = 3'd7;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_META = 4'b0010,
    PH_NOTE = 4'b0100,
    PH_DUR  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [MAX_CH-1:0][7:0]  countdown;
    logic [MAX_CH-1:0][11:0] shadow_period;
    logic [MAX_CH-1:0][3:0]  shadow_level;
    logic [5:0]              shadow_mixer;
    logic [MAX_CH-1:0][11:0] shown_period;
    logic [MAX_CH-1:0][3:0]  shown_level;
    logic [5:0]              shown_mixer;
    logic [MAX_CH-1:0]       pending_mask;
    phase_e                  byte_phase;
    logic [CH_W-1:0]         serving_channel;
    logic [7:0]              held_meta;
    logic                    playing;
  } state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] song_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  fetch_channel;
    logic [11:0] period_a;
    logic [11:0] period_b;
    logic [11:0] period_c;
    logic [3:0]  level_a;
    logic [3:0]  level_b;
    logic [3:0]  level_c;
    logic [5:0]  mixer_bits;
  } res_t;

  localparam logic [11:0] PERIOD_ROM [128] = '{
    12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
    12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
    12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFE4, 12'hEFF, 12'hE28,
    12'hD5C, 12'hC9D, 12'hBE7, 12'hB3C, 12'hA9B, 12'hA02, 12'h973, 12'h8EB,
    12'h86B, 12'h7F2, 12'h780, 12'h714, 12'h6AE, 12'h64E, 12'h5F4, 12'h59E,
    12'h54D, 12'h501, 12'h4B9, 12'h475, 12'h435, 12'h3F9, 12'h3C0, 12'h38A,
    12'h357, 12'h327, 12'h2FA, 12'h2CF, 12'h2A7, 12'h281, 12'h25D, 12'h23B,
    12'h21B, 12'h1FC, 12'h1E0, 12'h1C5, 12'h1AC, 12'h194, 12'h17D, 12'h168,
    12'h153, 12'h140, 12'h12E, 12'h11D, 12'h10D, 12'h0FE, 12'h0F0, 12'h0E2,
    12'h0D6, 12'h0CA, 12'h0BE, 12'h0B4, 12'h0AA, 12'h0A0, 12'h097, 12'h08F,
    12'h087, 12'h07F, 12'h078, 12'h071, 12'h06B, 12'h065, 12'h05F, 12'h05A,
    12'h055, 12'h050, 12'h04C, 12'h047, 12'h043, 12'h040, 12'h03C, 12'h039,
    12'h035, 12'h032, 12'h030, 12'h02D, 12'h02A, 12'h028, 12'h026, 12'h024,
    12'h022, 12'h020, 12'h01E, 12'h01C, 12'h01B, 12'h019, 12'h018, 12'h016,
    12'h015, 12'h014, 12'h013, 12'h012, 12'h011, 12'h010, 12'h00F, 12'h00E,
    12'h00D, 12'h00D, 12'h00C, 12'h00B, 12'h00B, 12'h00A, 12'h009, 12'h009
  };

endpackage

`default_nettype wire

// ===== hw/rtl/tcns_stream_if.sv =====
// Valid/ready stream interface carrying one item of a given payload type.
// No dependencies.
`default_nettype none

interface tcns_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tcns_step.sv =====
// Next-state and result logic for one request item of the note sequencer.
// Depends on tcns_pkg.
`default_nettype none

module tcns_step #(
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  tcns_pkg::state_t state_i,
  input  logic [1:0]       req_type_i,
  input  logic [7:0]       song_byte_i,
  output tcns_pkg::state_t state_o,
  output tcns_pkg::res_t   result_o
);

  function automatic tcns_pkg::state_t clear_song(tcns_pkg::state_t s);
    tcns_pkg::state_t r;
    r = s;
    for (int i = 0; i < tcns_pkg::MAX_CH; i++) begin
      r.countdown[i]     = 8'd1;
      r.shadow_period[i] = '0;
      r.shadow_level[i]  = '0;
    end
    r.shadow_mixer    = '0;
    r.pending_mask    = '0;
    r.byte_phase      = tcns_pkg::PH_IDLE;
    r.serving_channel = '0;
    r.held_meta       = '0;
    return r;
  endfunction

  tcns_pkg::state_t              n;
  logic [1:0]                    kind;
  logic [tcns_pkg::CH_W-1:0]     chan;
  logic [tcns_pkg::CH_W-1:0]     ch;
  logic [2:0]                    noise_idx;
  logic [tcns_pkg::MAX_CH-1:0]   pm;
  logic [7:0]                    meta;
  logic [2:0]                    dur;
  logic                          do_apply;
  logic                          do_finish;
  logic                          do_next;
  logic                          found;
  logic [tcns_pkg::CH_W-1:0]     sel;

  assign ch        = state_i.serving_channel;
  assign noise_idx = {1'b0, ch} + 3'd3;

  always_comb begin
    n         = state_i;
    kind      = tcns_pkg::KIND_NONE;
    chan      = '0;
    pm        = '0;
    meta      = state_i.held_meta;
    dur       = '0;
    do_apply  = 1'b0;
    do_finish = 1'b0;
    do_next   = 1'b0;
    found     = 1'b0;
    sel       = '0;

    case (req_type_i) inside
      tcns_pkg::REQ_START, tcns_pkg::REQ_STOP: begin
        n         = clear_song(state_i);
        n.playing = (req_type_i == tcns_pkg::REQ_START);
      end
      tcns_pkg::REQ_TICK: begin
        if (!state_i.playing) begin
          kind = tcns_pkg::KIND_NONE;
        end else if (state_i.byte_phase != tcns_pkg::PH_IDLE) begin
          kind = tcns_pkg::KIND_FETCH;
          chan = ch;
        end else begin
          for (int i = 0; i < tcns_pkg::MAX_CH; i++) begin
            if (i < NUM_CHANNELS) begin
              n.countdown[i] = state_i.countdown[i] - 8'd1;
              pm[i]          = (n.countdown[i] == 8'd0);
            end
          end
          n.pending_mask = pm;
          do_next        = 1'b1;
        end
      end
      default: begin
        if (state_i.byte_phase == tcns_pkg::PH_IDLE ||
            ch >= tcns_pkg::CH_W'(tcns_pkg::MAX_CH)) begin
          kind = tcns_pkg::KIND_NONE;
        end else begin
          unique case (state_i.byte_phase)
            tcns_pkg::PH_META: begin
              n.held_meta = song_byte_i;
              meta        = song_byte_i;
              if ((song_byte_i & tcns_pkg::META_NOTE_BIT) != 8'd0) begin
                n.byte_phase = tcns_pkg::PH_NOTE;
                kind         = tcns_pkg::KIND_FETCH;
                chan         = ch;
              end else begin
                do_apply = 1'b1;
              end
            end
            tcns_pkg::PH_NOTE: begin
              if (song_byte_i != 8'd0) begin
                n.shadow_period[ch]       = tcns_pkg::PERIOD_ROM[song_byte_i[6:0]];
                n.shadow_mixer[ch]        = 1'b0;
                n.shadow_mixer[noise_idx] = 1'b1;
              end else begin
                n.shadow_mixer[ch]        = 1'b1;
                n.shadow_mixer[noise_idx] = 1'b0;
              end
              do_apply = 1'b1;
            end
            tcns_pkg::PH_DUR: begin
              n.countdown[ch] = song_byte_i;
              do_finish       = 1'b1;
            end
            default: begin
              kind = tcns_pkg::KIND_NONE;
            end
          endcase
        end
      end
    endcase

    if (do_apply) begin
      n.shadow_level[ch] = meta[3:0];
      dur                = meta[6:4];
      if (dur == tcns_pkg::DUR_RESTART) begin
        n    = clear_song(n);
        kind = tcns_pkg::KIND_RESTART;
      end else if (dur == tcns_pkg::DUR_EXTENDED) begin
        n.byte_phase = tcns_pkg::PH_DUR;
        kind         = tcns_pkg::KIND_FETCH;
        chan         = ch;
      end else begin
        n.countdown[ch] = {5'd0, dur};
        do_finish       = 1'b1;
      end
    end

    if (do_finish) begin
      n.pending_mask[ch] = 1'b0;
      do_next            = 1'b1;
    end

    if (do_next) begin
      for (int i = tcns_pkg::MAX_CH - 1; i >= 0; i--) begin
        if (n.pending_mask[i] && i < NUM_CHANNELS) begin
          found = 1'b1;
          sel   = tcns_pkg::CH_W'(i);
        end
      end
      if (found) begin
        n.serving_channel = sel;
        n.byte_phase      = tcns_pkg::PH_META;
        kind              = tcns_pkg::KIND_FETCH;
        chan              = sel;
      end else begin
        n.pending_mask = '0;
        n.shown_period = n.shadow_period;
        n.shown_level  = n.shadow_level;
        n.shown_mixer  = n.shadow_mixer;
        n.byte_phase   = tcns_pkg::PH_IDLE;
        kind           = tcns_pkg::KIND_FRAME;
      end
    end
  end

  assign state_o = n;

  always_comb begin
    result_o.result_kind   = kind;
    result_o.fetch_channel = (kind == tcns_pkg::KIND_FETCH) ? chan : 2'd0;
    result_o.period_a      = n.shown_period[0];
    result_o.period_b      = n.shown_period[1];
    result_o.period_c      = n.shown_period[2];
    result_o.level_a       = n.shown_level[0];
    result_o.level_b       = n.shown_level[1];
    result_o.level_c       = n.shown_level[2];
    result_o.mixer_bits    = n.shown_mixer;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcns_out_stage.sv =====
// Result register of the note sequencer: holds one result item until taken.
// Depends on tcns_pkg and tcns_stream_if.
`default_nettype none

module tcns_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  tcns_pkg::res_t data_i,
  output logic           ready_o,
  tcns_stream_if.source  res_o
);

  logic           valid_q;
  logic           valid_d;
  tcns_pkg::res_t data_q;

  // a new item may enter if empty or if the held one leaves in the same cycle
  assign ready_o = !valid_q || res_o.ready;
  assign valid_d = load_i || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign res_o.valid   = valid_q;
  assign res_o.payload = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/three_channel_note_sequencer_unit.sv =====
// Three-channel note sequencer: state registers, step logic, result register.
// Depends on tcns_pkg, tcns_stream_if, tcns_step and tcns_out_stage.
// A result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; the result register takes a new item in the
// cycle its held one is taken, so only a stalled output holds back the input.
// Reset: async active low; stopped, countdowns 1, idle, other state 0.
`default_nettype none

module three_channel_note_sequencer_unit #(
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tcns_stream_if.sink   req_i,
  tcns_stream_if.source res_o
);

  tcns_pkg::state_t state_q;
  tcns_pkg::state_t state_d;
  tcns_pkg::state_t state_rst;
  tcns_pkg::res_t   result;
  logic             load;
  logic             ready;

  assign load        = req_i.valid && ready;
  assign req_i.ready = ready;

  always_comb begin
    state_rst            = '0;
    state_rst.byte_phase = tcns_pkg::PH_IDLE;
    for (int i = 0; i < tcns_pkg::MAX_CH; i++) begin
      state_rst.countdown[i] = 8'd1;
    end
  end

  tcns_step #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_step (
    .state_i     (state_q),
    .req_type_i  (req_i.payload.req_type),
    .song_byte_i (req_i.payload.song_byte),
    .state_o     (state_d),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= state_rst;
    end else if (load) begin
      state_q <= state_d;
    end
  end

  tcns_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .data_i  (result),
    .ready_o (ready),
    .res_o   (res_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.byte_phase != tcns_pkg::PH_IDLE) |-> state_q.playing)
    else $error("fetch in progress while stopped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.byte_phase != tcns_pkg::PH_IDLE) |->
      (32'(state_q.serving_channel) < NUM_CHANNELS))
    else $error("serving a channel that does not exist");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (req_i.payload.req_type == tcns_pkg::REQ_START ||
              req_i.payload.req_type == tcns_pkg::REQ_STOP)) |=>
      (state_q.byte_phase == tcns_pkg::PH_IDLE && state_q.pending_mask == '0 &&
       res_o.valid && res_o.payload.result_kind == tcns_pkg::KIND_NONE))
    else $error("start or stop did not clear the song state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && req_i.payload.req_type == tcns_pkg::REQ_TICK && !state_q.playing) |=>
      (res_o.valid && res_o.payload.result_kind == tcns_pkg::KIND_NONE))
    else $error("tick while stopped was not ignored");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for three_channel_note_sequencer_unit: a scripted opening,
// then song-shaped random traffic scored item by item against an in-bench predictor.
// Depends on tcns_pkg, tcns_stream_if and the unit under test.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcns_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 925;
  localparam int unsigned LONG_HOLD    = 120;
  localparam int unsigned SCRIPT_LEN   = 25;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] data;
    logic       typed;
    logic [1:0] kind;
    logic [1:0] chan;
  } script_row_t;

  typedef enum int {FLOW_FULL, FLOW_MOSTLY, FLOW_SPARSE, FLOW_TOGGLE} flow_e;

  logic clk_i;
  logic rst_ni;

  tcns_stream_if #(.payload_t(req_t)) req_if ();
  tcns_stream_if #(.payload_t(res_t)) res_if ();

  three_channel_note_sequencer_unit #(.NUM_CHANNELS(MAX_CH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // predicted sequencer state
  logic [7:0]        tick_left    [MAX_CH];
  logic [11:0]       draft_period [MAX_CH];
  logic [3:0]        draft_level  [MAX_CH];
  logic [5:0]        draft_mixer;
  logic [11:0]       live_period  [MAX_CH];
  logic [3:0]        live_level   [MAX_CH];
  logic [5:0]        live_mixer;
  logic [MAX_CH-1:0] due_mask;
  phase_e            seq_phase;
  logic [1:0]        cur_ch;
  logic [7:0]        meta_hold;
  logic              song_on;

  res_t awaited_results [$];

  int errors        = 0;
  int results_seen  = 0;
  int frames_seen   = 0;
  int fetches_seen  = 0;
  int restarts_seen = 0;
  int items_sent    = 0;
  int burst_left    = 0;

  function automatic void wipe_song();
    for (int i = 0; i < MAX_CH; i++) begin
      tick_left[i]    = 8'd1;
      draft_period[i] = '0;
      draft_level[i]  = '0;
    end
    draft_mixer = '0;
    due_mask    = '0;
    seq_phase   = PH_IDLE;
    cur_ch      = '0;
    meta_hold   = '0;
  endfunction

  function automatic res_t shown_frame(logic [1:0] kind, logic [1:0] ch);
    res_t r;
    r.result_kind   = kind;
    r.fetch_channel = (kind == KIND_FETCH) ? ch : 2'd0;
    r.period_a      = live_period[0];
    r.period_b      = live_period[1];
    r.period_c      = live_period[2];
    r.level_a       = live_level[0];
    r.level_b       = live_level[1];
    r.level_c       = live_level[2];
    r.mixer_bits    = live_mixer;
    return r;
  endfunction

  // lowest due channel gets the next fetch; with none left the frame goes out
  function automatic res_t serve_next();
    logic found;
    found = 1'b0;
    for (int i = 0; i < MAX_CH; i++) begin
      if (!found && due_mask[i]) begin
        found  = 1'b1;
        cur_ch = 2'(i);
      end
    end
    if (found) begin
      seq_phase = PH_META;
      return shown_frame(KIND_FETCH, cur_ch);
    end
    due_mask    = '0;
    live_period = draft_period;
    live_level  = draft_level;
    live_mixer  = draft_mixer;
    seq_phase   = PH_IDLE;
    return shown_frame(KIND_FRAME, 2'd0);
  endfunction

  function automatic res_t close_channel();
    due_mask[cur_ch] = 1'b0;
    return serve_next();
  endfunction

  function automatic res_t apply_meta();
    logic [2:0] dur;
    dur = meta_hold[6:4];
    draft_level[cur_ch] = meta_hold[3:0];
    if (dur == DUR_RESTART) begin
      wipe_song();
      return shown_frame(KIND_RESTART, 2'd0);
    end
    if (dur == DUR_EXTENDED) begin
      seq_phase = PH_DUR;
      return shown_frame(KIND_FETCH, cur_ch);
    end
    tick_left[cur_ch] = {5'd0, dur};
    return close_channel();
  endfunction

  function automatic res_t predict_step(req_t q);
    res_t r;
    case (q.req_type) inside
      REQ_START, REQ_STOP: begin
        wipe_song();
        song_on = (q.req_type == REQ_START);
        r = shown_frame(KIND_NONE, 2'd0);
      end
      REQ_TICK: begin
        if (!song_on) begin
          r = shown_frame(KIND_NONE, 2'd0);
        end else if (seq_phase != PH_IDLE) begin
          r = shown_frame(KIND_FETCH, cur_ch);
        end else begin
          due_mask = '0;
          for (int i = 0; i < MAX_CH; i++) begin
            tick_left[i] = tick_left[i] - 8'd1;
            if (tick_left[i] == 8'd0) due_mask[i] = 1'b1;
          end
          r = serve_next();
        end
      end
      default: begin
        case (seq_phase)
          PH_META: begin
            meta_hold = q.song_byte;
            if ((q.song_byte & META_NOTE_BIT) != 8'd0) begin
              seq_phase = PH_NOTE;
              r = shown_frame(KIND_FETCH, cur_ch);
            end else begin
              r = apply_meta();
            end
          end
          PH_NOTE: begin
            if (q.song_byte != 8'd0) begin
              draft_period[cur_ch]           = PERIOD_ROM[q.song_byte[6:0]];
              draft_mixer[cur_ch]            = 1'b0;
              draft_mixer[int'(cur_ch) + 3]  = 1'b1;
            end else begin
              draft_mixer[cur_ch]            = 1'b1;
              draft_mixer[int'(cur_ch) + 3]  = 1'b0;
            end
            r = apply_meta();
          end
          PH_DUR: begin
            tick_left[cur_ch] = q.song_byte;
            r = close_channel();
          end
          default: r = shown_frame(KIND_NONE, 2'd0);
        endcase
      end
    endcase
    return r;
  endfunction

  // mostly answers the outstanding fetch with a sensible byte, sometimes not
  function automatic req_t pick_request();
    req_t        q;
    int unsigned roll;
    int unsigned sub;
    logic [2:0]  dur;
    q.song_byte = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    if (!song_on) begin
      q.req_type = (roll < 70) ? REQ_START : (roll < 85) ? REQ_TICK : REQ_BYTE;
    end else if (seq_phase == PH_IDLE) begin
      q.req_type = (roll < 88) ? REQ_TICK : (roll < 94) ? REQ_BYTE :
                   (roll < 97) ? REQ_START : REQ_STOP;
    end else if (roll < 92) begin
      q.req_type = REQ_BYTE;
      case (seq_phase)
        PH_META: begin
          dur = (sub < 3) ? DUR_RESTART : (sub < 18) ? DUR_EXTENDED :
                3'($urandom_range(1, 4));
          q.song_byte = {($urandom_range(0, 9) < 6), dur, 4'($urandom_range(0, 15))};
        end
        PH_NOTE: if (sub < 20) q.song_byte = 8'd0;
        default: begin
          q.song_byte = (sub < 10) ? 8'd0 : (sub < 20) ? 8'hFF :
                        8'($urandom_range(1, 6));
        end
      endcase
    end else begin
      q.req_type = (roll < 95) ? REQ_TICK : (roll < 97) ? REQ_START :
                   (roll < 98) ? REQ_STOP : REQ_BYTE;
    end
    return q;
  endfunction

  task automatic offer(req_t q);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    req_if.valid   <= 1'b1;
    req_if.payload <= q;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
  endtask

  task automatic check_field(string field, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t ns: result kind expected none, got 0x%0h", $time,
                 res_if.payload.result_kind);
      end else begin
        want = awaited_results.pop_front();
        if (want.result_kind == KIND_FRAME) frames_seen++;
        else if (want.result_kind == KIND_FETCH) fetches_seen++;
        else if (want.result_kind == KIND_RESTART) restarts_seen++;
        check_field("result_kind",   want.result_kind,   res_if.payload.result_kind);
        check_field("fetch_channel", want.fetch_channel, res_if.payload.fetch_channel);
        check_field("period_a",      want.period_a,      res_if.payload.period_a);
        check_field("period_b",      want.period_b,      res_if.payload.period_b);
        check_field("period_c",      want.period_c,      res_if.payload.period_c);
        check_field("level_a",       want.level_a,       res_if.payload.level_a);
        check_field("level_b",       want.level_b,       res_if.payload.level_b);
        check_field("level_c",       want.level_c,       res_if.payload.level_c);
        check_field("mixer_bits",    want.mixer_bits,    res_if.payload.mixer_bits);
      end
    end
  end

  // receiver: changing stall patterns, plus one long hold-off to back up the input
  initial begin
    flow_e flow;
    int    span;
    int    held;
    logic  long_done;
    res_if.ready = 1'b0;
    flow      = FLOW_FULL;
    span      = 0;
    long_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!long_done && results_seen >= 300) begin
        long_done = 1'b1;
        res_if.ready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          @(posedge clk_i);
          held++;
        end
      end
      if (span == 0) begin
        flow = flow_e'($urandom_range(0, 3));
        span = $urandom_range(16, 96);
      end
      span--;
      case (flow)
        FLOW_FULL:   res_if.ready <= 1'b1;
        FLOW_MOSTLY: res_if.ready <= ($urandom_range(0, 3) != 0);
        FLOW_SPARSE: res_if.ready <= ($urandom_range(0, 9) < 3);
        default:     res_if.ready <= span[0];
      endcase
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    script_row_t script [SCRIPT_LEN];
    req_t        q;
    res_t        want;
    int          counted;

    // typed rows all fall before the first frame, so shown registers are zero
    script = '{
      '{REQ_TICK,  8'h00, 1'b1, KIND_NONE,    2'd0},  // tick while stopped
      '{REQ_STOP,  8'h00, 1'b1, KIND_NONE,    2'd0},
      '{REQ_START, 8'h00, 1'b1, KIND_NONE,    2'd0},
      '{REQ_TICK,  8'h00, 1'b1, KIND_FETCH,   2'd0},  // all channels due
      '{REQ_TICK,  8'h00, 1'b1, KIND_FETCH,   2'd0},  // fetch repeated
      '{REQ_BYTE,  8'hF5, 1'b0, KIND_NONE,    2'd0},  // note + extended duration
      '{REQ_BYTE,  8'hFF, 1'b0, KIND_NONE,    2'd0},  // top note
      '{REQ_BYTE,  8'h00, 1'b0, KIND_NONE,    2'd0},  // 256 ticks
      '{REQ_BYTE,  8'h9F, 1'b0, KIND_NONE,    2'd0},
      '{REQ_BYTE,  8'h80, 1'b0, KIND_NONE,    2'd0},  // note index masked to 0
      '{REQ_BYTE,  8'h80, 1'b0, KIND_NONE,    2'd0},
      '{REQ_BYTE,  8'h00, 1'b1, KIND_RESTART, 2'd0},  // rest note, restart
      '{REQ_TICK,  8'h00, 1'b1, KIND_FETCH,   2'd0},
      '{REQ_BYTE,  8'h21, 1'b0, KIND_NONE,    2'd0},
      '{REQ_BYTE,  8'h3E, 1'b0, KIND_NONE,    2'd0},
      '{REQ_BYTE,  8'hA3, 1'b0, KIND_NONE,    2'd0},
      '{REQ_BYTE,  8'h15, 1'b0, KIND_NONE,    2'd0},  // frame published
      '{REQ_TICK,  8'h00, 1'b0, KIND_NONE,    2'd0},  // nobody due
      '{REQ_TICK,  8'h00, 1'b0, KIND_NONE,    2'd0},
      '{REQ_BYTE,  8'h70, 1'b0, KIND_NONE,    2'd0},
      '{REQ_BYTE,  8'hFF, 1'b0, KIND_NONE,    2'd0},
      '{REQ_START, 8'h00, 1'b0, KIND_NONE,    2'd0},  // start mid-fetch
      '{REQ_TICK,  8'h00, 1'b0, KIND_NONE,    2'd0},
      '{REQ_STOP,  8'h00, 1'b0, KIND_NONE,    2'd0},
      '{REQ_BYTE,  8'h12, 1'b0, KIND_NONE,    2'd0}   // stray byte
    };

    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;

    wipe_song();
    for (int i = 0; i < MAX_CH; i++) begin
      live_period[i] = '0;
      live_level[i]  = '0;
    end
    live_mixer = '0;
    song_on    = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[k]) begin
      q.req_type  = script[k].req;
      q.song_byte = script[k].data;
      want = predict_step(q);
      if (script[k].typed) begin
        want               = '0;
        want.result_kind   = script[k].kind;
        want.fetch_channel = script[k].chan;
      end
      awaited_results.push_back(want);
      offer(q);
      items_sent++;
    end

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      q = pick_request();
      awaited_results.push_back(predict_step(q));
      offer(q);
      items_sent++;
      counted++;
    end
    req_if.valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d request items (%0d scripted); got back %0d frames, %0d byte fetches",
             items_sent, SCRIPT_LEN, frames_seen, fetches_seen);
    $display("and %0d restarts, with one %0d-cycle output hold-off; %0d field errors.",
             restarts_seen, LONG_HOLD, errors);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
